[rtl/dise_pkg.sv]
// Package for the display identification serial extractor.
// Holds the stream offsets, character codes, the source status type and small
// character helper functions. It depends on nothing.
package dise_pkg;

	localparam int TEXT_CHARS_DEF = 13;
	localparam int HEX_DIGITS = 8;

	// Positions inside a 128-byte block.
	localparam logic [6:0] DESC_BASE = 7'h36;
	localparam logic [6:0] EXT_COUNT_POS = 7'h7E;
	localparam logic [6:0] BLOCK_LAST_POS = 7'h7F;
	localparam logic [6:0] SERIAL_POS0 = 7'd12;
	localparam logic [6:0] SERIAL_POS1 = 7'd13;
	localparam logic [6:0] SERIAL_POS2 = 7'd14;
	localparam logic [6:0] SERIAL_POS3 = 7'd15;
	localparam logic [6:0] BLOCK_FIRST_POS = 7'd0;
	localparam logic [8:0] BLOCK_LIMIT = 9'd511;
	localparam logic [8:0] BASE_BLOCK = 9'd0;

	// Offsets inside an 18-byte descriptor.
	localparam logic [4:0] DOFF_HDR0 = 5'd0;
	localparam logic [4:0] DOFF_HDR2 = 5'd2;
	localparam logic [4:0] DOFF_TYPE = 5'd3;
	localparam logic [4:0] DOFF_TEXT = 5'd5;
	localparam logic [4:0] DOFF_LAST = 5'd17;

	localparam logic [7:0] DESC_TYPE_SERIAL = 8'hFF;
	localparam logic [7:0] DESC_TYPE_ASCII = 8'hFE;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] PRINT_LOW = 8'h20;
	localparam logic [7:0] PRINT_HIGH = 8'h7E;

	localparam logic [6:0] CHAR_NUL = 7'h00;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_QUEST = 7'h3F;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_NINE = 7'h39;
	localparam logic [6:0] CHAR_UA = 7'h41;
	localparam logic [6:0] CHAR_UF = 7'h46;
	localparam logic [6:0] CHAR_UZ = 7'h5A;
	localparam logic [6:0] CHAR_LA = 7'h61;
	localparam logic [6:0] CHAR_LZ = 7'h7A;

	typedef enum logic [1:0] {
		SRC_TEXT = 2'd0,
		SRC_HEX  = 2'd1,
		SRC_NONE = 2'd2
	} status_t;

	function automatic logic [6:0] printable(input logic [7:0] b);
		logic [6:0] c;
		if (b < PRINT_LOW || b > PRINT_HIGH) begin
			c = CHAR_QUEST;
		end else begin
			c = b[6:0];
		end
		return c;
	endfunction

	function automatic logic is_alnum(input logic [6:0] c);
		return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UA && c <= CHAR_UZ) ||
			(c >= CHAR_LA && c <= CHAR_LZ);
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_UA + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

[rtl/display_id_serial_extractor.sv]
// Top level of the display identification serial extractor.
// Depends on dise_pkg for offsets, character codes and helper functions.
//
// The block takes one byte of display identification data per cycle and
// keeps only counters, a 13-character text buffer and the picks of the
// current block, so bytes flow back to back with no gaps. Each descriptor
// text is judged (trimmed and checked) in the cycle after its last byte,
// which always lands before the block's choice at byte 127. On the byte that
// carries end_of_data the chosen string is loaded into a shift buffer and
// leaves one character per unstalled cycle: 1 to TEXT_CHARS characters for
// descriptor text, 8 for the hex serial, 1 for the none status. While that
// buffer drains, ordinary bytes of the next data set are still accepted;
// only a further final byte is held until the last character has been taken.
module display_id_serial_extractor #(
	parameter int TEXT_CHARS = dise_pkg::TEXT_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] serial_char,
	output logic [1:0] source_status,
	output logic       final_char
);
	import dise_pkg::*;

	localparam int BufChars = (TEXT_CHARS > HEX_DIGITS) ? TEXT_CHARS : HEX_DIGITS;
	localparam int TL_W = $clog2(TEXT_CHARS + 1);
	localparam int LEN_W = $clog2(BufChars + 1);
	localparam logic [4:0] TextEndOff = 5'(TEXT_CHARS + 5);

	// Stream position and block bookkeeping.
	logic [6:0] byte_pos_q, byte_pos_d;
	logic [8:0] block_num_q, block_num_d;
	logic [7:0] ext_total_q, ext_total_d;
	logic [31:0] num_serial_q, num_serial_d;
	logic tag_good_q, tag_good_d;
	logic hdr_match_q, hdr_match_d;
	logic [4:0] desc_off_q, desc_off_d;
	logic base_done_q, base_done_d;

	// Descriptor text being collected.
	logic [6:0] text_store_q [TEXT_CHARS];
	logic [6:0] text_store_d [TEXT_CHARS];
	logic [TL_W-1:0] text_len_q, text_len_d;
	logic text_ended_q, text_ended_d;
	logic [TL_W-1:0] first_ns_q, first_ns_d;
	logic [TL_W-1:0] end_ns_q, end_ns_d;
	logic seen_ns_q, seen_ns_d;
	logic has_alnum_q, has_alnum_d;
	logic judge_pend_q, judge_pend_d;

	// Pick of the current block and the overall choice.
	logic [6:0] block_pick_q [TEXT_CHARS];
	logic [6:0] block_pick_d [TEXT_CHARS];
	logic [LEN_W-1:0] pick_len_q, pick_len_d;
	logic pick_valid_q, pick_valid_d;
	logic [6:0] chosen_text_q [TEXT_CHARS];
	logic [6:0] chosen_text_d [TEXT_CHARS];
	logic [LEN_W-1:0] chosen_len_q, chosen_len_d;
	logic chosen_found_q, chosen_found_d;

	// Output shift buffer.
	logic [6:0] emit_text_q [BufChars];
	logic [6:0] emit_text_d [BufChars];
	logic [LEN_W-1:0] emit_left_q, emit_left_d;
	status_t emit_status_q, emit_status_d;
	logic emit_busy_q, emit_busy_d;

	// Judge of the collected text.
	logic [6:0] trimmed [TEXT_CHARS];
	logic [LEN_W-1:0] trim_len;
	logic judge_ok;

	logic data_fire;
	logic char_fire;
	logic final_fire;
	logic in_region;
	logic [6:0] text_ch;
	logic [TL_W-1:0] len_eff;
	logic ended_eff;
	logic seen_eff;
	logic eligible;

	assign char_valid = emit_busy_q;
	assign serial_char = emit_text_q[0];
	assign source_status = emit_status_q;
	assign final_char = (emit_left_q == LEN_W'(1));
	assign char_fire = char_valid && !char_stall;
	assign final_fire = char_fire && final_char;
	assign data_stall = emit_busy_q && end_of_data && !final_fire;
	assign data_fire = data_valid && !data_stall;
	assign in_region = (byte_pos_q >= DESC_BASE) && (byte_pos_q < EXT_COUNT_POS);
	assign text_ch = printable(data_byte);

	always_comb begin
		logic all_zero;
		logic all_f;
		for (int k = 0; k < TEXT_CHARS; k++) begin
			trimmed[k] = text_store_q[k];
			for (int m = 0; m < TEXT_CHARS; m++) begin
				if (m >= k && first_ns_q == TL_W'(m - k)) begin
					trimmed[k] = text_store_q[m];
				end
			end
		end
		trim_len = LEN_W'(end_ns_q) - LEN_W'(first_ns_q);
		all_zero = 1'b1;
		all_f = 1'b1;
		for (int k = 0; k < TEXT_CHARS; k++) begin
			if (k < HEX_DIGITS) begin
				all_zero = all_zero && (trimmed[k] == CHAR_ZERO);
				all_f = all_f && (trimmed[k] == CHAR_UF);
			end
		end
		// A string with a letter or digit is never empty after trimming.
		judge_ok = has_alnum_q && !(trim_len == LEN_W'(HEX_DIGITS) && (all_zero || all_f));
	end

	always_comb begin
		byte_pos_d = byte_pos_q;
		block_num_d = block_num_q;
		ext_total_d = ext_total_q;
		num_serial_d = num_serial_q;
		tag_good_d = tag_good_q;
		hdr_match_d = hdr_match_q;
		desc_off_d = desc_off_q;
		base_done_d = base_done_q;
		text_store_d = text_store_q;
		text_len_d = text_len_q;
		text_ended_d = text_ended_q;
		first_ns_d = first_ns_q;
		end_ns_d = end_ns_q;
		seen_ns_d = seen_ns_q;
		has_alnum_d = has_alnum_q;
		judge_pend_d = 1'b0;
		block_pick_d = block_pick_q;
		pick_len_d = pick_len_q;
		pick_valid_d = pick_valid_q;
		chosen_text_d = chosen_text_q;
		chosen_len_d = chosen_len_q;
		chosen_found_d = chosen_found_q;
		emit_text_d = emit_text_q;
		emit_left_d = emit_left_q;
		emit_status_d = emit_status_q;
		emit_busy_d = emit_busy_q;
		len_eff = text_len_q;
		ended_eff = text_ended_q;
		seen_eff = seen_ns_q;
		eligible = 1'b0;

		if (judge_pend_q && judge_ok) begin
			block_pick_d = trimmed;
			pick_len_d = trim_len;
			pick_valid_d = 1'b1;
		end

		if (char_fire) begin
			for (int k = 0; k < BufChars - 1; k++) begin
				emit_text_d[k] = emit_text_q[k + 1];
			end
			emit_left_d = emit_left_q - LEN_W'(1);
			emit_busy_d = !final_char;
		end

		if (data_fire) begin
			if (byte_pos_q == BLOCK_FIRST_POS) begin
				pick_valid_d = 1'b0;
				pick_len_d = '0;
				tag_good_d = (block_num_q == BASE_BLOCK) || (data_byte == BYTE_ZERO);
			end
			if (block_num_q == BASE_BLOCK) begin
				case (byte_pos_q)
					SERIAL_POS0: num_serial_d[7:0] = data_byte;
					SERIAL_POS1: num_serial_d[15:8] = data_byte;
					SERIAL_POS2: num_serial_d[23:16] = data_byte;
					SERIAL_POS3: num_serial_d[31:24] = data_byte;
					EXT_COUNT_POS: ext_total_d = data_byte;
					default: ;
				endcase
			end

			if (in_region) begin
				desc_off_d = (desc_off_q == DOFF_LAST) ? '0 : desc_off_q + 5'd1;
				if (desc_off_q == DOFF_HDR0) begin
					hdr_match_d = (data_byte == BYTE_ZERO);
				end else if (desc_off_q <= DOFF_HDR2) begin
					hdr_match_d = hdr_match_q && (data_byte == BYTE_ZERO);
				end else if (desc_off_q == DOFF_TYPE) begin
					hdr_match_d = hdr_match_q &&
						(data_byte == DESC_TYPE_SERIAL || data_byte == DESC_TYPE_ASCII);
				end
				if (desc_off_q == DOFF_TEXT) begin
					len_eff = '0;
					ended_eff = 1'b0;
					seen_eff = 1'b0;
					text_len_d = '0;
					text_ended_d = 1'b0;
					seen_ns_d = 1'b0;
					has_alnum_d = 1'b0;
					first_ns_d = '0;
					end_ns_d = '0;
				end
				if (desc_off_q >= DOFF_TEXT && desc_off_q < TextEndOff && !ended_eff) begin
					if (data_byte == BYTE_LF || data_byte == BYTE_ZERO) begin
						text_ended_d = 1'b1;
					end else if (len_eff < TL_W'(TEXT_CHARS)) begin
						for (int k = 0; k < TEXT_CHARS; k++) begin
							if (len_eff == TL_W'(k)) begin
								text_store_d[k] = text_ch;
							end
						end
						text_len_d = len_eff + TL_W'(1);
						// Track where the text starts and ends once spaces are trimmed.
						if (text_ch != CHAR_SPACE) begin
							if (!seen_eff) begin
								first_ns_d = len_eff;
							end
							seen_ns_d = 1'b1;
							end_ns_d = len_eff + TL_W'(1);
							if (is_alnum(text_ch)) begin
								has_alnum_d = 1'b1;
							end
						end
					end
				end
				judge_pend_d = (desc_off_q == DOFF_LAST) && hdr_match_q && !pick_valid_q &&
					!end_of_data;
			end else begin
				desc_off_d = '0;
			end

			if (byte_pos_q == BLOCK_LAST_POS) begin
				eligible = (block_num_q == BASE_BLOCK) ||
					(block_num_q <= {1'b0, ext_total_q} && tag_good_q);
				if (eligible && pick_valid_q && !chosen_found_q) begin
					chosen_text_d = block_pick_q;
					chosen_len_d = pick_len_q;
					chosen_found_d = 1'b1;
				end
				if (block_num_q == BASE_BLOCK) begin
					base_done_d = 1'b1;
				end
				if (block_num_q != BLOCK_LIMIT) begin
					block_num_d = block_num_q + 9'd1;
				end
			end
			byte_pos_d = byte_pos_q + 7'd1;

			if (end_of_data) begin
				emit_busy_d = 1'b1;
				if (base_done_d && chosen_found_d && chosen_len_d != '0) begin
					for (int k = 0; k < TEXT_CHARS; k++) begin
						emit_text_d[k] = chosen_text_d[k];
					end
					emit_left_d = chosen_len_d;
					emit_status_d = SRC_TEXT;
				end else if (base_done_d && num_serial_d != '0 && num_serial_d != '1) begin
					for (int k = 0; k < HEX_DIGITS; k++) begin
						emit_text_d[k] = hex_char(num_serial_d[31 - 4 * k -: 4]);
					end
					emit_left_d = LEN_W'(HEX_DIGITS);
					emit_status_d = SRC_HEX;
				end else begin
					emit_text_d[0] = CHAR_NUL;
					emit_left_d = LEN_W'(1);
					emit_status_d = SRC_NONE;
				end
				// The next byte starts a new data set.
				byte_pos_d = '0;
				block_num_d = '0;
				ext_total_d = '0;
				num_serial_d = '0;
				tag_good_d = 1'b1;
				hdr_match_d = 1'b0;
				desc_off_d = '0;
				base_done_d = 1'b0;
				text_len_d = '0;
				text_ended_d = 1'b0;
				first_ns_d = '0;
				end_ns_d = '0;
				seen_ns_d = 1'b0;
				has_alnum_d = 1'b0;
				judge_pend_d = 1'b0;
				pick_len_d = '0;
				pick_valid_d = 1'b0;
				chosen_len_d = '0;
				chosen_found_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			block_num_q <= '0;
			ext_total_q <= '0;
			num_serial_q <= '0;
			tag_good_q <= 1'b1;
			hdr_match_q <= 1'b0;
			desc_off_q <= '0;
			base_done_q <= 1'b0;
			text_len_q <= '0;
			text_ended_q <= 1'b0;
			first_ns_q <= '0;
			end_ns_q <= '0;
			seen_ns_q <= 1'b0;
			has_alnum_q <= 1'b0;
			judge_pend_q <= 1'b0;
			pick_len_q <= '0;
			pick_valid_q <= 1'b0;
			chosen_len_q <= '0;
			chosen_found_q <= 1'b0;
			emit_left_q <= '0;
			emit_status_q <= SRC_NONE;
			emit_busy_q <= 1'b0;
		end else begin
			byte_pos_q <= byte_pos_d;
			block_num_q <= block_num_d;
			ext_total_q <= ext_total_d;
			num_serial_q <= num_serial_d;
			tag_good_q <= tag_good_d;
			hdr_match_q <= hdr_match_d;
			desc_off_q <= desc_off_d;
			base_done_q <= base_done_d;
			text_len_q <= text_len_d;
			text_ended_q <= text_ended_d;
			first_ns_q <= first_ns_d;
			end_ns_q <= end_ns_d;
			seen_ns_q <= seen_ns_d;
			has_alnum_q <= has_alnum_d;
			judge_pend_q <= judge_pend_d;
			pick_len_q <= pick_len_d;
			pick_valid_q <= pick_valid_d;
			chosen_len_q <= chosen_len_d;
			chosen_found_q <= chosen_found_d;
			emit_left_q <= emit_left_d;
			emit_status_q <= emit_status_d;
			emit_busy_q <= emit_busy_d;
		end
	end

	always_ff @(posedge clk) begin
		text_store_q <= text_store_d;
		block_pick_q <= block_pick_d;
		chosen_text_q <= chosen_text_d;
		emit_text_q <= emit_text_d;
	end

`ifndef SYNTHESIS
	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		final_fire && !(data_fire && end_of_data) |=> !char_valid)
		else $error("char_valid stayed high after the final character");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		data_fire && end_of_data |=> char_valid)
		else $error("final byte did not start an output string");

	a_none_shape: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && source_status == SRC_NONE |-> serial_char == CHAR_NUL && final_char)
		else $error("none status must be a single zero character");

	a_off_region: assert property (@(posedge clk) disable iff (!arst_n)
		desc_off_q != DOFF_HDR0 |-> desc_off_q <= DOFF_LAST &&
			byte_pos_q > DESC_BASE && byte_pos_q < EXT_COUNT_POS)
		else $error("descriptor offset out of step with the byte position");

	a_judge_once: assert property (@(posedge clk) disable iff (!arst_n)
		judge_pend_q |-> !pick_valid_q)
		else $error("text judged although the block already has a pick");
`endif

endmodule

[test/tb.sv]
// Testbench for display_id_serial_extractor: streams display identification data sets
// through the byte port and checks every emitted serial character against a predictor.
// Depends on dise_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
	import dise_pkg::*;

	localparam int DESC_LEN = 18;
	localparam int TEXT_LEN = 5;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam logic [7:0] DESC_TYPE_NAME = 8'hFC;
	localparam logic [7:0] TAG_OTHER = 8'h02;

	typedef struct {
		logic [6:0] ch;
		status_t src;
		logic last;
	} char_rec_t;

	class serial_scoreboard;
		char_rec_t pending_chars[$];
		int errors;
		int chars_expected;
		int chars_seen;
		logic [6:0] pos;
		int blk;
		logic [7:0] ext_total;
		logic [31:0] serial_num;
		bit tag_ok, hdr_ok, txt_done, pick_ok, chosen_ok, base_done;
		logic [6:0] txt[13];
		logic [6:0] pick[13];
		logic [6:0] chosen[13];
		int txt_len, pick_len, chosen_len;

		function new();
			errors = 0;
			chars_expected = 0;
			chars_seen = 0;
			restart();
		endfunction

		function void restart();
			pos = 7'd0;
			blk = 0;
			ext_total = 8'h00;
			serial_num = 32'h0;
			tag_ok = 1'b1;
			hdr_ok = 1'b0;
			txt_len = 0;
			txt_done = 1'b0;
			pick_ok = 1'b0;
			pick_len = 0;
			chosen_len = 0;
			chosen_ok = 1'b0;
			base_done = 1'b0;
		endfunction

		// Trims spaces and applies the rejection rules; a surviving string becomes
		// the pick of the current block.
		function void judge_text();
			int s, e, k;
			bit all0, allf, alnum;
			s = 0;
			e = txt_len;
			alnum = 1'b0;
			while (s < e && txt[s] == CHAR_SPACE) s++;
			while (e > s && txt[e - 1] == CHAR_SPACE) e--;
			if (e == s) return;
			if (e - s == HEX_DIGITS) begin
				all0 = 1'b1;
				allf = 1'b1;
				for (k = s; k < e; k++) begin
					if (txt[k] != CHAR_ZERO) all0 = 1'b0;
					if (txt[k] != CHAR_UF) allf = 1'b0;
				end
				if (all0 || allf) return;
			end
			for (k = s; k < e; k++) begin
				if ((txt[k] >= CHAR_ZERO && txt[k] <= CHAR_NINE) ||
						(txt[k] >= CHAR_UA && txt[k] <= CHAR_UZ) ||
						(txt[k] >= CHAR_LA && txt[k] <= CHAR_LZ)) begin
					alnum = 1'b1;
				end
			end
			if (!alnum) return;
			for (k = s; k < e; k++) pick[k - s] = txt[k];
			pick_len = e - s;
			pick_ok = 1'b1;
		endfunction

		function void desc_byte(int off, logic [7:0] b);
			if (off == 0) begin
				hdr_ok = (b == BYTE_ZERO);
			end else if (off <= DOFF_HDR2) begin
				hdr_ok = hdr_ok && (b == BYTE_ZERO);
			end else if (off == DOFF_TYPE) begin
				hdr_ok = hdr_ok && (b == DESC_TYPE_SERIAL || b == DESC_TYPE_ASCII);
			end else if (off >= DOFF_TEXT) begin
				if (off == DOFF_TEXT) begin
					txt_len = 0;
					txt_done = 1'b0;
				end
				if (!txt_done) begin
					if (b == BYTE_LF || b == BYTE_ZERO) begin
						txt_done = 1'b1;
					end else if (txt_len < TEXT_CHARS_DEF) begin
						txt[txt_len] = (b < PRINT_LOW || b > PRINT_HIGH) ? CHAR_QUEST : b[6:0];
						txt_len++;
					end
				end
				if (off == DOFF_LAST && hdr_ok && !pick_ok) judge_text();
			end
		endfunction

		// Advances the predicted state by one accepted item and queues the
		// characters that a final byte releases.
		function void take_byte(logic [7:0] b, logic eod);
			int p, k, n;
			char_rec_t rec;
			logic [3:0] nib;
			p = pos;
			n = 0;
			if (p == BLOCK_FIRST_POS) begin
				pick_ok = 1'b0;
				pick_len = 0;
				tag_ok = (blk == 0) ? 1'b1 : (b == BYTE_ZERO);
			end
			if (blk == 0) begin
				if (p >= SERIAL_POS0 && p <= SERIAL_POS3) serial_num[8 * (p - SERIAL_POS0) +: 8] = b;
				if (p == EXT_COUNT_POS) ext_total = b;
			end
			if (p >= DESC_BASE && p < EXT_COUNT_POS) desc_byte((p - DESC_BASE) % DESC_LEN, b);
			if (p == BLOCK_LAST_POS) begin
				if ((blk == 0 || (blk <= ext_total && tag_ok)) && pick_ok && !chosen_ok) begin
					chosen = pick;
					chosen_len = pick_len;
					chosen_ok = 1'b1;
				end
				if (blk == 0) base_done = 1'b1;
				if (blk < BLOCK_LIMIT) blk++;
			end
			pos = pos + 7'd1;
			if (!eod) return;

			if (base_done && chosen_ok && chosen_len > 0) begin
				for (k = 0; k < chosen_len; k++) begin
					rec.ch = chosen[k];
					rec.src = SRC_TEXT;
					rec.last = (k == chosen_len - 1);
					pending_chars.push_back(rec);
				end
				n = chosen_len;
			end else if (base_done && serial_num != 32'h0 && serial_num != 32'hFFFF_FFFF) begin
				for (k = 0; k < HEX_DIGITS; k++) begin
					nib = serial_num[28 - 4 * k +: 4];
					rec.ch = (nib < 4'd10) ? CHAR_ZERO + {3'b000, nib} :
						CHAR_UA + {3'b000, nib} - 7'd10;
					rec.src = SRC_HEX;
					rec.last = (k == HEX_DIGITS - 1);
					pending_chars.push_back(rec);
				end
				n = HEX_DIGITS;
			end else begin
				rec.ch = CHAR_NUL;
				rec.src = SRC_NONE;
				rec.last = 1'b1;
				pending_chars.push_back(rec);
				n = 1;
			end
			chars_expected += n;
			restart();
		endfunction

		task report(input string what);
			$display("mismatch at char %0d: %s", chars_seen, what);
			errors++;
		endtask

		task check_char(input logic [6:0] c, input logic [1:0] s, input logic f);
			char_rec_t want;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected char %h status %0d last %b", c, s, f));
			end else begin
				want = pending_chars.pop_front();
				if (c !== want.ch) report($sformatf("serial_char %h, want %h", c, want.ch));
				if (s !== want.src) report($sformatf("source_status %0d, want %0d", s, want.src));
				if (f !== want.last) report($sformatf("final_char %b, want %b", f, want.last));
			end
			chars_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic data_valid = 1'b0;
	logic data_stall;
	logic [7:0] data_byte = 8'h00;
	logic end_of_data = 1'b0;
	logic char_valid;
	logic char_stall = 1'b1;
	logic [6:0] serial_char;
	logic [1:0] source_status;
	logic final_char;

	serial_scoreboard sb;
	logic [7:0] blk_buf[128];
	logic [7:0] set_q[$];
	string alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	string punct_set = " -.!#?/";
	bit tx_busy = 1'b1;
	bit rx_busy = 1'b1;
	int rx_hold = 0;
	int items_sent = 0;
	int cycles = 0;

	display_id_serial_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.end_of_data(end_of_data),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.serial_char(serial_char),
		.source_status(source_status),
		.final_char(final_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			sb.check_char(serial_char, source_status, final_char);
		end
	end

	// Output side. A hold request is served after the current wait, and the
	// stall stays up for the whole requested stretch.
	initial begin : rx_side
		int w;
		forever begin
			if (rx_hold > 0) begin
				char_stall <= 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			if ($urandom_range(0, 31) == 0) rx_busy = !rx_busy;
			w = rx_busy ? $urandom_range(0, 10) : 0;
			if (w > 0) begin
				char_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			char_stall <= 1'b0;
			do @(posedge clk); while (!char_valid && rx_hold == 0);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eod);
		int gap;
		gap = tx_busy ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_data <= eod;
		do @(posedge clk); while (data_stall);
		sb.take_byte(b, eod);
		items_sent++;
	endtask

	task automatic send_set();
		int i;
		for (i = 0; i < set_q.size(); i++) send_byte(set_q[i], i == set_q.size() - 1);
		set_q.delete();
	endtask

	task automatic wait_drained();
		data_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_chars.size() != 0);
	endtask

	// Random block whose descriptors are not text descriptors.
	task automatic fill_block(input logic [7:0] tag);
		int i;
		for (i = 0; i < 128; i++) blk_buf[i] = 8'($urandom);
		blk_buf[0] = tag;
		blk_buf[EXT_COUNT_POS] = BYTE_ZERO;
		for (i = 0; i < 4; i++) blk_buf[DESC_BASE + DESC_LEN * i] = 8'h01;
	endtask

	task automatic put_desc(input int d, input logic [7:0] dtype, input string s);
		int at, i;
		at = DESC_BASE + DESC_LEN * d;
		blk_buf[at] = BYTE_ZERO;
		blk_buf[at + 1] = BYTE_ZERO;
		blk_buf[at + 2] = BYTE_ZERO;
		blk_buf[at + 3] = dtype;
		blk_buf[at + 4] = BYTE_ZERO;
		for (i = 0; i < TEXT_CHARS_DEF; i++) begin
			blk_buf[at + TEXT_LEN + i] = (i < s.len()) ? s[i] :
				(i == s.len()) ? BYTE_LF : PRINT_LOW;
		end
	endtask

	task automatic put_serial(input logic [31:0] v);
		blk_buf[SERIAL_POS0] = v[7:0];
		blk_buf[SERIAL_POS1] = v[15:8];
		blk_buf[SERIAL_POS2] = v[23:16];
		blk_buf[SERIAL_POS3] = v[31:24];
	endtask

	task automatic add_block();
		int i;
		for (i = 0; i < 128; i++) set_q.push_back(blk_buf[i]);
	endtask

	// Text descriptor with random content of a randomly chosen flavor.
	task automatic rand_desc(input int d);
		int kind, len, i, at;
		logic [7:0] t[13];
		logic [7:0] fillc, term;
		bit pad_spaces;
		at = DESC_BASE + DESC_LEN * d + TEXT_LEN;
		kind = $urandom_range(0, 11);
		len = $urandom_range(0, 13);
		for (i = 0; i < 13; i++) t[i] = alnum_set[$urandom_range(0, alnum_set.len() - 1)];
		case (kind)
			4: for (i = 0; i < 13; i++) t[i] = 8'($urandom_range(32, 126));
			5: for (i = 0; i < 13; i++) t[i] = 8'($urandom);
			6: begin
				len = $urandom_range(8, 10);
				fillc = $urandom_range(0, 1) ? {1'b0, CHAR_ZERO} : {1'b0, CHAR_UF};
				for (i = 0; i < 13; i++) t[i] = fillc;
				if (len == 10) begin
					t[0] = PRINT_LOW;
					t[9] = PRINT_LOW;
				end
			end
			7: for (i = 0; i < 13; i++) t[i] = punct_set[$urandom_range(0, punct_set.len() - 1)];
			8: begin
				len = $urandom_range(5, 13);
				t[0] = PRINT_LOW;
				t[1] = PRINT_LOW;
				t[len - 1] = PRINT_LOW;
			end
			9: len = 13;
			10: for (i = 0; i < 13; i++) t[i] = PRINT_LOW;
			default: ;
		endcase
		put_desc(d, $urandom_range(0, 1) ? DESC_TYPE_SERIAL : DESC_TYPE_ASCII, "");
		if (kind == 11) blk_buf[at - TEXT_LEN + $urandom_range(0, 3)] = DESC_TYPE_NAME;
		term = $urandom_range(0, 1) ? BYTE_LF : BYTE_ZERO;
		pad_spaces = $urandom_range(0, 1);
		for (i = 0; i < 13; i++) begin
			blk_buf[at + i] = (i < len) ? t[i] : (i == len) ? term :
				pad_spaces ? PRINT_LOW : 8'($urandom);
		end
	endtask

	task automatic rand_set();
		int roll, n_ext, b, d, cut, n;
		logic [31:0] sn;
		tx_busy = ($urandom_range(0, 3) != 0);
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			n = $urandom_range(1, 300);
			repeat (n) set_q.push_back(8'($urandom));
			send_set();
			return;
		end
		n_ext = (roll < 40) ? 0 : (roll < 80) ? 1 : $urandom_range(2, 3);
		fill_block(8'($urandom));
		roll = $urandom_range(0, 9);
		blk_buf[EXT_COUNT_POS] = (roll < 7) ? 8'(n_ext) :
			(roll < 9) ? 8'($urandom_range(0, 3)) : 8'hFF;
		roll = $urandom_range(0, 9);
		sn = (roll < 7) ? $urandom : (roll < 8) ? 32'h0 :
			(roll < 9) ? 32'hFFFF_FFFF : (32'h1 << $urandom_range(0, 31));
		put_serial(sn);
		for (d = 0; d < 4; d++) if ($urandom_range(0, 9) < 3) rand_desc(d);
		add_block();
		for (b = 0; b < n_ext; b++) begin
			fill_block(($urandom_range(0, 9) < 8) ? BYTE_ZERO : 8'($urandom_range(1, 255)));
			for (d = 0; d < 4; d++) if ($urandom_range(0, 9) < 5) rand_desc(d);
			add_block();
		end
		if ($urandom_range(0, 99) < 12) begin
			cut = $urandom_range(1, set_q.size());
			while (set_q.size() > cut) set_q.delete(set_q.size() - 1);
		end
		send_set();
	endtask

	initial begin : stimulus
		int at, rand_items, rand_chars;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone final byte, then a base block that stops one byte short.
		set_q.push_back(8'hFF);
		send_set();
		fill_block(BYTE_ZERO);
		put_serial(32'h1234_5678);
		add_block();
		set_q.delete(set_q.size() - 1);
		send_set();

		// Numeric serial fallback: every hex digit, then the two rejected values.
		fill_block(BYTE_ZERO);
		put_serial(32'h89AB_CDEF);
		add_block();
		send_set();
		fill_block(8'hFF);
		put_serial(32'h0123_4567);
		add_block();
		send_set();
		fill_block(BYTE_ZERO);
		put_serial(32'h0);
		add_block();
		send_set();
		fill_block(BYTE_ZERO);
		put_serial(32'hFFFF_FFFF);
		add_block();
		send_set();

		// Leading and trailing spaces go, inner ones stay.
		fill_block(BYTE_ZERO);
		put_serial(32'h0000_0042);
		put_desc(0, DESC_TYPE_SERIAL, "  AB 12  ");
		add_block();
		send_set();

		// All four descriptors hold rejected strings.
		fill_block(BYTE_ZERO);
		put_serial(32'h0000_ABCD);
		put_desc(0, DESC_TYPE_SERIAL, "00000000");
		put_desc(1, DESC_TYPE_ASCII, " FFFFFFFF ");
		put_desc(2, DESC_TYPE_SERIAL, "   ");
		put_desc(3, DESC_TYPE_ASCII, "-?-!");
		add_block();
		send_set();

		// Empty text, then a full 13-character text with no terminator.
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "");
		put_desc(1, DESC_TYPE_ASCII, "ABCDEFGHIJKLM");
		add_block();
		send_set();

		// Broken header, a name descriptor, and control or high bytes turned into '?'.
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "BAD");
		blk_buf[DESC_BASE + 1] = 8'h01;
		put_desc(1, DESC_TYPE_NAME, "NAME");
		put_desc(2, DESC_TYPE_ASCII, "xxxxxxxxxxxxx");
		at = DESC_BASE + 2 * DESC_LEN + TEXT_LEN;
		blk_buf[at] = 8'h09;
		blk_buf[at + 1] = 8'h7F;
		blk_buf[at + 2] = 8'h80;
		blk_buf[at + 3] = 8'hFF;
		blk_buf[at + 4] = 8'h0D;
		add_block();
		send_set();

		// A NUL byte ends the text just as a line feed does.
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "SN1ZZZZZ");
		blk_buf[DESC_BASE + TEXT_LEN + 3] = BYTE_ZERO;
		add_block();
		send_set();

		// Extension blocks: used when counted, complete and tagged zero.
		fill_block(BYTE_ZERO);
		put_serial(32'h0);
		blk_buf[EXT_COUNT_POS] = 8'd1;
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(1, DESC_TYPE_ASCII, "EXT1");
		add_block();
		send_set();

		fill_block(BYTE_ZERO);
		put_desc(3, DESC_TYPE_SERIAL, "BASE");
		blk_buf[EXT_COUNT_POS] = 8'd1;
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "EXT");
		add_block();
		send_set();

		fill_block(BYTE_ZERO);
		blk_buf[EXT_COUNT_POS] = 8'd3;
		add_block();
		fill_block(TAG_OTHER);
		put_desc(0, DESC_TYPE_SERIAL, "NO");
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(2, DESC_TYPE_SERIAL, "YES");
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "LATER");
		add_block();
		send_set();

		fill_block(BYTE_ZERO);
		put_serial(32'h0);
		blk_buf[EXT_COUNT_POS] = 8'd1;
		add_block();
		fill_block(BYTE_ZERO);
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "LATE");
		add_block();
		send_set();

		// The extension text is complete but the block itself is cut short.
		fill_block(BYTE_ZERO);
		put_serial(32'hFEDC_BA98);
		blk_buf[EXT_COUNT_POS] = 8'd1;
		add_block();
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_SERIAL, "CUT");
		add_block();
		while (set_q.size() > 228) set_q.delete(set_q.size() - 1);
		send_set();

		// Output held off while a long string and several short sets arrive, so
		// the block has to stall a final byte.
		wait_drained();
		tx_busy = 1'b0;
		rx_hold = HOLD_CYCLES;
		fill_block(BYTE_ZERO);
		put_desc(0, DESC_TYPE_ASCII, "Z0123456789YX");
		add_block();
		send_set();
		repeat (3) begin
			set_q.push_back(8'($urandom));
			send_set();
		end
		wait_drained();
		tx_busy = 1'b1;

		rand_items = items_sent;
		rand_chars = sb.chars_expected;
		while (items_sent - rand_items < 420 || sb.chars_expected - rand_chars < 48) begin
			rand_set();
			if ($urandom_range(0, 5) == 0) wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/dise_pkg.sv
rtl/display_id_serial_extractor.sv
test/tb.sv
